// ===== rtl/tdor_pkg.sv =====
// Shared types and constants for the torus dimension-order router.
`timescale 1ns / 1ps
`default_nettype none

package tdor_pkg;

    localparam int NODE_W   = 10;
    localparam int SIDE_W   = 6;
    localparam int COORD_W  = 5;
    localparam int HOP_W    = 6;
    localparam int DIR_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_SIDE = 32;

    localparam int DIV_STEPS = NODE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd1;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd2;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd4;

    typedef struct packed {
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] dest_node;
    } tdor_in_t;

    typedef struct packed {
        logic [NODE_W-1:0] route_node;
        logic [HOP_W-1:0]  hop_index;
        logic [DIR_W-1:0]  move_dir;
        logic              last;
        logic              range_error;
    } tdor_out_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_first;
        logic emit_hop;
    } tdor_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic first_last;
        logic hop_last;
    } tdor_stat_t;

endpackage

`default_nettype wire

// ===== rtl/torus_dimension_order_router.sv =====
// Top level of the torus dimension-order router.
// A request is loaded, divided by the column count in ST_DIV, and its source result
// is registered on m_valid; each further hop result follows from ST_HOP whenever the
// output slot is free. The divider produces one quotient bit a cycle.
// A new request is accepted only once the last result of the previous one is emitted.
// Reset: synchronous active-low aresetn; grid_rows and grid_cols return to 1.
`timescale 1ns / 1ps
`default_nettype none

module torus_dimension_order_router
    import tdor_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIDE_W-1:0]    cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire tdor_in_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output tdor_out_t                 m_data
);

    tdor_cmd_t  cmd;
    tdor_stat_t stat;

    tdor_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tdor_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.range_error |-> m_data.last && m_data.route_node == '0 &&
        m_data.hop_index == '0)
        else $error("range error result is not a single empty result");

    a_hop_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=>
        m_valid && m_data.hop_index == HOP_W'($past(m_data.hop_index) + HOP_W'(1)))
        else $error("next hop result missing or out of order");

    a_hop_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hop_index != '0 |-> m_data.move_dir != DIR_NONE)
        else $error("hop result without a move");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous request in progress");

endmodule

`default_nettype wire

// ===== rtl/tdor_datapath.sv =====
// Datapath: config registers, coordinate divider, hop stepper and result register.
`timescale 1ns / 1ps
`default_nettype none

module tdor_datapath
    import tdor_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIDE_W-1:0]    cfg_wdata,
    input  wire tdor_in_t             s_data,
    input  wire tdor_cmd_t            cmd,
    output tdor_stat_t                stat,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output tdor_out_t                 m_data
);

    function automatic logic [SIDE_W-1:0] side_eff(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > SIDE_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [SIDE_W-1:0]  rows_reg, cols_reg;
    logic [SIDE_W-1:0]  rows_eff, cols_eff;
    logic [NODE_W-1:0]  src_reg, dst_reg;
    logic               err_reg;
    logic [NODE_W-1:0]  qs_reg, qd_reg;
    logic [COORD_W-1:0] rs_reg, rd_reg;
    logic [COORD_W-1:0] cur_col_reg, cur_row_reg, dest_col_reg, dest_row_reg;
    logic [HOP_W-1:0]   hop_reg;
    tdor_out_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [2*SIDE_W-1:0] total;
    logic                range_bad;

    logic [SIDE_W-1:0]  trial_s, trial_d, diff_s, diff_d;
    logic               ge_s, ge_d;

    logic [COORD_W-1:0] half_c, half_r, cols_m1, rows_m1;
    logic               col_fwd, row_fwd, east, south;
    logic [COORD_W-1:0] col_mag, row_mag;
    logic [COORD_W-1:0] next_col, next_row;
    logic [DIR_W-1:0]   hop_dir;
    logic [2*SIDE_W-1:0] node_prod;
    logic [2*SIDE_W-1:0] node_sum;
    logic [HOP_W-1:0]   hop_inc;

    assign rows_eff = side_eff(rows_reg);
    assign cols_eff = side_eff(cols_reg);

    assign total     = {{SIDE_W{1'b0}}, rows_eff} * {{SIDE_W{1'b0}}, cols_eff};
    assign range_bad = ({2'b00, s_data.source_node} >= total) ||
                       ({2'b00, s_data.dest_node} >= total);

    // Restoring division by the column count, one quotient bit a cycle.
    assign trial_s = {rs_reg, qs_reg[NODE_W-1]};
    assign trial_d = {rd_reg, qd_reg[NODE_W-1]};
    assign ge_s    = trial_s >= cols_eff;
    assign ge_d    = trial_d >= cols_eff;
    assign diff_s  = trial_s - cols_eff;
    assign diff_d  = trial_d - cols_eff;

    assign half_c  = cols_eff[SIDE_W-1:1];
    assign half_r  = rows_eff[SIDE_W-1:1];
    assign cols_m1 = COORD_W'(cols_eff - SIDE_W'(1));
    assign rows_m1 = COORD_W'(rows_eff - SIDE_W'(1));

    assign col_fwd = dest_col_reg > cur_col_reg;
    assign row_fwd = dest_row_reg > cur_row_reg;
    assign col_mag = col_fwd ? (dest_col_reg - cur_col_reg) : (cur_col_reg - dest_col_reg);
    assign row_mag = row_fwd ? (dest_row_reg - cur_row_reg) : (cur_row_reg - dest_row_reg);
    assign east    = col_fwd ^ (col_mag > half_c);
    assign south   = row_fwd ^ (row_mag > half_r);

    always_comb begin
        next_col = cur_col_reg;
        next_row = cur_row_reg;
        if (cur_col_reg != dest_col_reg) begin
            if (east) begin
                hop_dir  = DIR_EAST;
                next_col = (cur_col_reg == cols_m1) ? '0 : cur_col_reg + COORD_W'(1);
            end else begin
                hop_dir  = DIR_WEST;
                next_col = (cur_col_reg == '0) ? cols_m1 : cur_col_reg - COORD_W'(1);
            end
        end else if (south) begin
            hop_dir  = DIR_SOUTH;
            next_row = (cur_row_reg == rows_m1) ? '0 : cur_row_reg + COORD_W'(1);
        end else begin
            hop_dir  = DIR_NORTH;
            next_row = (cur_row_reg == '0) ? rows_m1 : cur_row_reg - COORD_W'(1);
        end
    end

    assign node_prod = {{(2*SIDE_W-COORD_W){1'b0}}, next_row} * {{SIDE_W{1'b0}}, cols_eff};
    assign node_sum  = node_prod + {{(2*SIDE_W-COORD_W){1'b0}}, next_col};
    assign hop_inc   = hop_reg + HOP_W'(1);

    assign stat.slot_free  = !out_valid_reg || m_ready;
    assign stat.first_last = err_reg || (src_reg == dst_reg);
    assign stat.hop_last   = (next_col == dest_col_reg) && (next_row == dest_row_reg);

    always_comb begin
        out_next       = out_reg;
        out_valid_next = m_ready ? 1'b0 : out_valid_reg;
        if (cmd.emit_first) begin
            out_valid_next = 1'b1;
            if (err_reg) begin
                out_next.route_node  = '0;
                out_next.hop_index   = '0;
                out_next.move_dir    = DIR_NONE;
                out_next.last        = 1'b1;
                out_next.range_error = 1'b1;
            end else begin
                out_next.route_node  = src_reg;
                out_next.hop_index   = '0;
                out_next.move_dir    = DIR_NONE;
                out_next.last        = src_reg == dst_reg;
                out_next.range_error = 1'b0;
            end
        end else if (cmd.emit_hop) begin
            out_valid_next       = 1'b1;
            out_next.route_node  = node_sum[NODE_W-1:0];
            out_next.hop_index   = hop_inc;
            out_next.move_dir    = hop_dir;
            out_next.last        = stat.hop_last;
            out_next.range_error = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg      <= SIDE_W'(1);
            cols_reg      <= SIDE_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_GRID_ROWS) begin
                rows_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_GRID_COLS) begin
                cols_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (cmd.load) begin
            src_reg <= s_data.source_node;
            dst_reg <= s_data.dest_node;
            err_reg <= range_bad;
            qs_reg  <= s_data.source_node;
            qd_reg  <= s_data.dest_node;
            rs_reg  <= '0;
            rd_reg  <= '0;
        end else if (cmd.div_step) begin
            qs_reg <= {qs_reg[NODE_W-2:0], ge_s};
            qd_reg <= {qd_reg[NODE_W-2:0], ge_d};
            rs_reg <= ge_s ? diff_s[COORD_W-1:0] : trial_s[COORD_W-1:0];
            rd_reg <= ge_d ? diff_d[COORD_W-1:0] : trial_d[COORD_W-1:0];
        end
        if (cmd.emit_first && !err_reg) begin
            cur_col_reg  <= rs_reg;
            cur_row_reg  <= qs_reg[COORD_W-1:0];
            dest_col_reg <= rd_reg;
            dest_row_reg <= qd_reg[COORD_W-1:0];
            hop_reg      <= '0;
        end else if (cmd.emit_hop) begin
            cur_col_reg <= next_col;
            cur_row_reg <= next_row;
            hop_reg     <= hop_inc;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/tdor_ctrl.sv =====
// Controller: sequences accept, division, source result and hop results.
`timescale 1ns / 1ps
`default_nettype none

module tdor_ctrl
    import tdor_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire tdor_stat_t stat,
    output tdor_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_FIRST = 2'd2;
    localparam logic [1:0] ST_HOP   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                if (stat.slot_free) begin
                    cmd.emit_first = 1'b1;
                    state_next     = stat.first_last ? ST_IDLE : ST_HOP;
                end
            end
            ST_HOP: begin
                if (stat.slot_free) begin
                    cmd.emit_hop = 1'b1;
                    if (stat.hop_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the torus dimension-order router: a directed table, then random routes.
`timescale 1ns / 1ps
module tb;
    import tdor_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PAUSE   = 16;
    localparam int DRAIN_CYCLES = 60;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 60;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 21;
    localparam int DIR_ROWS     = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [SIDE_W-1:0]      val;
        tdor_in_t               req;
        logic                   typed;
        tdor_out_t              want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIDE_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    tdor_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    tdor_out_t            m_data;

    logic [SIDE_W-1:0] rows_reg = 6'd1;
    logic [SIDE_W-1:0] cols_reg = 6'd1;
    tdor_out_t         route_q[$];
    int                fail_count   = 0;
    int                items_sent   = 0;
    int                quiet_cycles = 0;
    int                burst_left   = 0;
    bit                pace_on      = 1'b1;

    torus_dimension_order_router u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic void queue_want(tdor_out_t r);
        route_q.insert(route_q.size(), r);
    endfunction

    function automatic int eff_side(logic [SIDE_W-1:0] raw);
        if (raw == 0) return 1;
        if (raw > MAX_SIDE) return MAX_SIDE;
        return int'(raw);
    endfunction

    function automatic int wrap_offset(int from, int to, int side);
        int d;
        int mag;
        d = to - from;
        mag = (d < 0) ? -d : d;
        if (mag > side / 2) d = (d > 0) ? d - side : d + side;
        return d;
    endfunction

    function automatic void plan_route(tdor_in_t req);
        int rows;
        int cols;
        int src;
        int dst;
        int cc;
        int cr;
        int dc;
        int dr;
        int dx;
        int dy;
        int hops;
        tdor_out_t r;
        rows = eff_side(rows_reg);
        cols = eff_side(cols_reg);
        src = int'(req.source_node);
        dst = int'(req.dest_node);
        r = '0;
        if (src >= rows * cols || dst >= rows * cols) begin
            r.last = 1'b1;
            r.range_error = 1'b1;
            queue_want(r);
            return;
        end
        cc = src % cols;
        cr = src / cols;
        dc = dst % cols;
        dr = dst / cols;
        hops = 0;
        r.route_node = req.source_node;
        r.move_dir = DIR_NONE;
        r.last = (src == dst);
        queue_want(r);
        while (cc != dc || cr != dr) begin
            dx = wrap_offset(cc, dc, cols);
            dy = wrap_offset(cr, dr, rows);
            if (dx > 0) begin
                r.move_dir = DIR_EAST;
                cc = (cc + 1) % cols;
            end else if (dx < 0) begin
                r.move_dir = DIR_WEST;
                cc = (cc + cols - 1) % cols;
            end else if (dy > 0) begin
                r.move_dir = DIR_SOUTH;
                cr = (cr + 1) % rows;
            end else begin
                r.move_dir = DIR_NORTH;
                cr = (cr + rows - 1) % rows;
            end
            hops++;
            r.route_node = NODE_W'(cr * cols + cc);
            r.hop_index = HOP_W'(hops);
            r.last = (cc == dc && cr == dr);
            queue_want(r);
        end
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic dir_row_t req_row(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
        dir_row_t r;
        r = '0;
        r.kind = ROW_REQ;
        r.req.source_node = src;
        r.req.dest_node = dst;
        return r;
    endfunction

    function automatic dir_row_t chk_row(logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
                                         tdor_out_t want);
        dir_row_t r;
        r = req_row(src, dst);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic tdor_out_t range_err();
        tdor_out_t r;
        r = '0;
        r.move_dir = DIR_NONE;
        r.last = 1'b1;
        r.range_error = 1'b1;
        return r;
    endfunction

    function automatic tdor_out_t lone_hop(logic [NODE_W-1:0] node);
        tdor_out_t r;
        r = '0;
        r.route_node = node;
        r.move_dir = DIR_NONE;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [SIDE_W-1:0] pick_side();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return SIDE_W'($urandom_range(1, 8));
        if (pick == 6) return SIDE_W'(MAX_SIDE);
        if (pick == 7) return '0;
        if (pick == 8) return SIDE_W'($urandom_range(MAX_SIDE + 1, 63));
        return SIDE_W'($urandom_range(9, MAX_SIDE - 1));
    endfunction

    function automatic tdor_in_t rand_req();
        tdor_in_t r;
        int total;
        int pick;
        total = eff_side(rows_reg) * eff_side(cols_reg);
        pick = $urandom_range(0, 19);
        r.source_node = NODE_W'($urandom_range(0, total - 1));
        r.dest_node = NODE_W'($urandom_range(0, total - 1));
        if (pick < 2) begin
            r.source_node = NODE_W'($urandom);
            r.dest_node = NODE_W'($urandom);
        end else if (pick == 2 && total < 1024) begin
            if ($urandom_range(0, 1) == 0) r.dest_node = NODE_W'($urandom_range(total, 1023));
            else r.source_node = NODE_W'($urandom_range(total, 1023));
        end else if (pick == 3) begin
            r.dest_node = r.source_node;
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_req(input tdor_in_t req, input bit typed, input tdor_out_t want);
        s_data <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (typed) queue_want(want);
        else plan_route(req);
        if (pace_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] val);
        s_valid <= 1'b0;
        while (route_q.size() != 0) @(posedge aclk);
        repeat (IDLE_PAUSE) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_GRID_ROWS) rows_reg = val;
        else if (idx == CFG_GRID_COLS) cols_reg = val;
    endtask

    initial begin
        dir_row_t dir_tab [DIR_ROWS];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        dir_tab = '{
            chk_row(10'd0, 10'd0, lone_hop(10'd0)),
            chk_row(10'd1, 10'd0, range_err()),
            chk_row(10'd1023, 10'd1023, range_err()),
            cfg_row(CFG_GRID_ROWS, 6'd0),
            cfg_row(CFG_GRID_COLS, 6'd63),
            req_row(10'd0, 10'd16),
            req_row(10'd16, 10'd0),
            req_row(10'd31, 10'd0),
            chk_row(10'd0, 10'd32, range_err()),
            cfg_row(CFG_GRID_ROWS, 6'd32),
            cfg_row(CFG_GRID_COLS, 6'd32),
            req_row(10'd0, 10'd1023),
            req_row(10'd0, 10'd528),
            req_row(10'd528, 10'd0),
            chk_row(10'd1023, 10'd1023, lone_hop(10'd1023)),
            req_row(10'd1023, 10'd0),
            cfg_row(CFG_GRID_ROWS, 6'd5),
            cfg_row(CFG_GRID_COLS, 6'd3),
            req_row(10'd0, 10'd14),
            req_row(10'd14, 10'd0),
            chk_row(10'd15, 10'd0, range_err()),
            chk_row(10'd0, 10'd15, range_err()),
            chk_row(10'd7, 10'd7, lone_hop(10'd7)),
            cfg_row(CFG_UNUSED, 6'd1),
            req_row(10'd14, 10'd1),
            cfg_row(CFG_GRID_ROWS, 6'd32),
            cfg_row(CFG_GRID_COLS, 6'd1),
            req_row(10'd0, 10'd16),
            req_row(10'd16, 10'd0),
            req_row(10'd31, 10'd0),
            chk_row(10'd32, 10'd0, range_err())
        };
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) write_reg(dir_tab[i].idx, dir_tab[i].val);
            else send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
        end
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_reg(CFG_GRID_ROWS, pick_side());
            write_reg(CFG_GRID_COLS, pick_side());
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, SIDE_W'($urandom));
            pace_on = (ph % 3 != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) send_req(rand_req(), 1'b0, '0);
        end
        s_valid <= 1'b0;
        while (route_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        int  rx_cycle;
        bit  held;
        rx_cycle = 0;
        held = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (!held && items_sent >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                case ((rx_cycle / 97) % 3)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_ready <= ((rx_cycle % 5) < 3);
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        tdor_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (route_q.size() == 0) begin
                $error("unexpected result route_node %0d", m_data.route_node);
                fail_count++;
            end else begin
                want = route_q.pop_front();
                check_field("route_node", want.route_node, m_data.route_node);
                check_field("hop_index", want.hop_index, m_data.hop_index);
                check_field("move_dir", want.move_dir, m_data.move_dir);
                check_field("last", want.last, m_data.last);
                check_field("range_error", want.range_error, m_data.range_error);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
rtl/tdor_pkg.sv
rtl/tdor_datapath.sv
rtl/tdor_ctrl.sv
rtl/torus_dimension_order_router.sv
tb/tb.sv
